>>> hw/rtl/did_name_response_parser_top_macros.svh
// Assertion macros used by the readout module of the label extractor.
`ifndef DID_NAME_RESPONSE_PARSER_TOP_MACROS_SVH
`define DID_NAME_RESPONSE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dnrp assertion failed");

// Next-cycle implication, checked outside reset.
`define DNRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dnrp assertion failed");

`endif

>>> hw/rtl/dnrp_pkg.sv
// Package with shared constants and types of the label extractor.
`timescale 1ns / 1ps

package dnrp_pkg;

    localparam int LABEL_STORE_DEF = 31;

    localparam int CAP_W  = 6;
    localparam int LEN_W  = 6;
    localparam int LIM_W  = 7;
    localparam int CHAR_W = 7;
    localparam int OUT_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [7:0] PAT_BYTE0  = 8'h62;
    localparam logic [7:0] PAT_BYTE1  = 8'hf1;
    localparam logic [7:0] PAT_BYTE2  = 8'h97;
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7e;
    localparam logic [7:0] TERM_ZERO  = 8'h00;
    localparam logic [7:0] TERM_ONES  = 8'hff;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [LEN_W-1:0] len;
    } run_end_t;

endpackage

>>> hw/rtl/did_name_response_parser_top.sv
// Top level of the identifier label extractor for diagnostic responses.
`timescale 1ns / 1ps

// Usage:
// A payload byte is transferred on data_byte and last_byte at a rising edge where start
// is high and busy is low. Bytes within a payload may arrive in every cycle.
// The block looks for the sequence 62 F1 97 and collects the printable label after it
// into an internal label memory, one byte per cycle.
// On the byte marked last, busy rises. A missing or invalid label gives a single
// not-found transfer in the next cycle. Otherwise the n label characters follow as n
// transfers in consecutive cycles; each passes the readout state register and then the
// registered read of the label memory, which is read at one address per cycle.
// Each result is shown for one cycle, flagged by result_valid; the receiver cannot stall.
// busy falls in the cycle after the final result.
// The capacity register is written over cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high and writes are expected only while the block is idle.
// Reset clears the run state and sets the capacity to 32; the label memory is not cleared.

module did_name_response_parser_top #(
    parameter int LABEL_STORE = dnrp_pkg::LABEL_STORE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dnrp_pkg::CAP_W-1:0]  cfg_data,
    output logic                        result_valid,
    output logic                        found,
    output logic [dnrp_pkg::CHAR_W-1:0] label_char,
    output logic [dnrp_pkg::OUT_W-1:0]  char_index,
    output logic [dnrp_pkg::OUT_W-1:0]  label_length,
    output logic                        last_result
);

    localparam int CW = $clog2(LABEL_STORE + 1);
    localparam int AW = (LABEL_STORE > 1) ? $clog2(LABEL_STORE) : 1;

    logic                        accept;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [dnrp_pkg::CHAR_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [dnrp_pkg::CHAR_W-1:0] rd_data;
    dnrp_pkg::run_end_t          run_end;

    assign accept = start && !busy;

    dnrp_scanner #(
        .LABEL_STORE (LABEL_STORE),
        .CW          (CW),
        .AW          (AW)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .run_end   (run_end)
    );

    dnrp_label_ram #(
        .DEPTH (LABEL_STORE),
        .AW    (AW)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dnrp_readout #(
        .LABEL_STORE (LABEL_STORE),
        .CW          (CW),
        .AW          (AW)
    ) u_readout (
        .clk          (clk),
        .rst_n        (rst_n),
        .run_end      (run_end),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .busy         (busy),
        .result_valid (result_valid),
        .found        (found),
        .label_char   (label_char),
        .char_index   (char_index),
        .label_length (label_length),
        .last_result  (last_result)
    );

endmodule

>>> hw/rtl/dnrp_label_ram.sv
// Label store: single write port, registered read port.
`timescale 1ns / 1ps

module dnrp_label_ram #(
    parameter int DEPTH = dnrp_pkg::LABEL_STORE_DEF,
    parameter int AW    = 5
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [dnrp_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [dnrp_pkg::CHAR_W-1:0] rd_data
);

    logic [dnrp_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [dnrp_pkg::CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/dnrp_scanner.sv
// Byte scanner: pattern search, label collection and capacity register.
`timescale 1ns / 1ps

module dnrp_scanner #(
    parameter int LABEL_STORE = dnrp_pkg::LABEL_STORE_DEF,
    parameter int CW          = 5,
    parameter int AW          = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dnrp_pkg::CAP_W-1:0]  cfg_data,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [dnrp_pkg::CHAR_W-1:0] wr_data,
    output dnrp_pkg::run_end_t          run_end
);

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_INVALID = 2'd3;

    localparam logic [dnrp_pkg::LIM_W-1:0] STORE_LIM = dnrp_pkg::LIM_W'(LABEL_STORE);

    logic [1:0]                  phase_reg, phase_next;
    logic [1:0]                  match_reg, match_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               trim_reg, trim_next;
    logic [dnrp_pkg::CAP_W-1:0]  cap_reg;
    logic [dnrp_pkg::CAP_W-1:0]  cap_m1;
    logic [dnrp_pkg::LIM_W-1:0]  limit;
    logic                        printable;

    assign cfg_ready = 1'b1;
    assign cap_m1    = (cap_reg == '0) ? '0 : cap_reg - 1'b1;
    assign limit     = (dnrp_pkg::LIM_W'(cap_m1) > STORE_LIM) ? STORE_LIM
                                                              : dnrp_pkg::LIM_W'(cap_m1);
    assign printable = (data_byte >= dnrp_pkg::PRINT_LOW) && (data_byte <= dnrp_pkg::PRINT_HIGH);
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = data_byte[dnrp_pkg::CHAR_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        count_next = count_reg;
        trim_next  = trim_reg;
        wr_en      = 1'b0;
        run_end    = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SEARCH:
                begin
                    if (match_reg == 2'd2 && data_byte == dnrp_pkg::PAT_BYTE2)
                    begin
                        match_next = 2'd0;
                        phase_next = PH_COLLECT;
                    end
                    else if (match_reg == 2'd1 && data_byte == dnrp_pkg::PAT_BYTE1)
                    begin
                        match_next = 2'd2;
                    end
                    else
                    begin
                        match_next = (data_byte == dnrp_pkg::PAT_BYTE0) ? 2'd1 : 2'd0;
                    end
                end
                PH_COLLECT:
                begin
                    priority if (dnrp_pkg::LIM_W'(count_reg) >= limit)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (data_byte == dnrp_pkg::TERM_ZERO ||
                             data_byte == dnrp_pkg::TERM_ONES)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (!printable)
                    begin
                        phase_next = PH_INVALID;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (data_byte != dnrp_pkg::PRINT_LOW)
                        begin
                            trim_next = count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (last_byte)
            begin
                run_end.valid = 1'b1;
                run_end.ok    = (phase_next == PH_COLLECT || phase_next == PH_DONE) &&
                                (trim_next != '0);
                run_end.len   = dnrp_pkg::LEN_W'(trim_next);
                phase_next    = PH_SEARCH;
                match_next    = 2'd0;
                count_next    = '0;
                trim_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            match_reg <= 2'd0;
            count_reg <= '0;
            trim_reg  <= '0;
            cap_reg   <= dnrp_pkg::CAP_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            count_reg <= count_next;
            trim_reg  <= trim_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/dnrp_readout.sv
// Readout sequencer: walks the label store and forms the result transfers.
`timescale 1ns / 1ps

`include "did_name_response_parser_top_macros.svh"

module dnrp_readout #(
    parameter int LABEL_STORE = dnrp_pkg::LABEL_STORE_DEF,
    parameter int CW          = 5,
    parameter int AW          = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dnrp_pkg::run_end_t          run_end,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [dnrp_pkg::CHAR_W-1:0] rd_data,
    output logic                        busy,
    output logic                        result_valid,
    output logic                        found,
    output logic [dnrp_pkg::CHAR_W-1:0] label_char,
    output logic [dnrp_pkg::OUT_W-1:0]  char_index,
    output logic [dnrp_pkg::OUT_W-1:0]  label_length,
    output logic                        last_result
);

    localparam logic RO_IDLE = 1'b0;
    localparam logic RO_READ = 1'b1;

    logic                       state_reg, state_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              len_reg, len_next;
    logic                       pv_reg, pv_next;
    logic                       pfound_reg, pfound_next;
    logic [dnrp_pkg::OUT_W-1:0] pidx_reg, pidx_next;
    logic [dnrp_pkg::OUT_W-1:0] plen_reg, plen_next;
    logic                       plast_reg, plast_next;
    logic                       at_end;

    assign at_end  = (CW'(idx_reg + 1'b1) == len_reg);
    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        pv_next     = 1'b0;
        pfound_next = pfound_reg;
        pidx_next   = pidx_reg;
        plen_next   = plen_reg;
        plast_next  = plast_reg;
        rd_en       = 1'b0;
        unique case (state_reg)
            RO_IDLE:
            begin
                if (run_end.valid)
                begin
                    if (run_end.ok)
                    begin
                        state_next = RO_READ;
                        idx_next   = '0;
                        len_next   = CW'(run_end.len);
                    end
                    else
                    begin
                        pv_next     = 1'b1;
                        pfound_next = 1'b0;
                        pidx_next   = '0;
                        plen_next   = '0;
                        plast_next  = 1'b1;
                    end
                end
            end
            RO_READ:
            begin
                rd_en       = 1'b1;
                pv_next     = 1'b1;
                pfound_next = 1'b1;
                pidx_next   = dnrp_pkg::OUT_W'(idx_reg);
                plen_next   = dnrp_pkg::OUT_W'(len_reg);
                plast_next  = at_end;
                if (at_end)
                begin
                    state_next = RO_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = RO_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RO_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            pv_reg    <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfound_reg <= pfound_next;
        pidx_reg   <= pidx_next;
        plen_reg   <= plen_next;
        plast_reg  <= plast_next;
    end

    assign busy         = (state_reg != RO_IDLE) || pv_reg;
    assign result_valid = pv_reg;
    assign found        = pfound_reg;
    assign label_char   = pfound_reg ? rd_data : '0;
    assign char_index   = pidx_reg;
    assign label_length = plen_reg;
    assign last_result  = plast_reg;

    `DNRP_ASSERT_NOW(a_idx_in_range, clk, rst_n, state_reg == RO_READ, idx_reg < len_reg)
    `DNRP_ASSERT_NEXT(a_not_found_single, clk, rst_n,
        state_reg == RO_IDLE && run_end.valid && !run_end.ok,
        pv_reg && !pfound_reg && plast_reg)
    `DNRP_ASSERT_NEXT(a_label_contiguous, clk, rst_n,
        pv_reg && pfound_reg && !plast_reg, pv_reg && pfound_reg)

endmodule
